FILE: design/afg_pkg.sv
// Shared types, operation codes and flag masks for the ALU flag generator.
package afg_pkg;

	localparam int unsigned CmdW  = 5;
	localparam int unsigned ByteW = 8;
	localparam int unsigned BitW  = 3;

	localparam logic [CmdW-1:0] CMD_ADD  = 5'd0;
	localparam logic [CmdW-1:0] CMD_SUB  = 5'd1;
	localparam logic [CmdW-1:0] CMD_CP   = 5'd2;
	localparam logic [CmdW-1:0] CMD_AND  = 5'd3;
	localparam logic [CmdW-1:0] CMD_OR   = 5'd4;
	localparam logic [CmdW-1:0] CMD_XOR  = 5'd5;
	localparam logic [CmdW-1:0] CMD_INC  = 5'd6;
	localparam logic [CmdW-1:0] CMD_DEC  = 5'd7;
	localparam logic [CmdW-1:0] CMD_RLCA = 5'd8;
	localparam logic [CmdW-1:0] CMD_RRCA = 5'd9;
	localparam logic [CmdW-1:0] CMD_RLA  = 5'd10;
	localparam logic [CmdW-1:0] CMD_RRA  = 5'd11;
	localparam logic [CmdW-1:0] CMD_RLC  = 5'd12;
	localparam logic [CmdW-1:0] CMD_RRC  = 5'd13;
	localparam logic [CmdW-1:0] CMD_RL   = 5'd14;
	localparam logic [CmdW-1:0] CMD_RR   = 5'd15;
	localparam logic [CmdW-1:0] CMD_SLA  = 5'd16;
	localparam logic [CmdW-1:0] CMD_SRA  = 5'd17;
	localparam logic [CmdW-1:0] CMD_SLL  = 5'd18;
	localparam logic [CmdW-1:0] CMD_SRL  = 5'd19;
	localparam logic [CmdW-1:0] CMD_BIT  = 5'd20;
	localparam logic [CmdW-1:0] CMD_DAA  = 5'd21;
	localparam logic [CmdW-1:0] CMD_SCF  = 5'd22;
	localparam logic [CmdW-1:0] CMD_CCF  = 5'd23;
	localparam logic [CmdW-1:0] CMD_CPL  = 5'd24;

	localparam logic [2:0] SH_RLC = 3'd0;
	localparam logic [2:0] SH_RRC = 3'd1;
	localparam logic [2:0] SH_RL  = 3'd2;
	localparam logic [2:0] SH_RR  = 3'd3;
	localparam logic [2:0] SH_SLA = 3'd4;
	localparam logic [2:0] SH_SRA = 3'd5;
	localparam logic [2:0] SH_SLL = 3'd6;
	localparam logic [2:0] SH_SRL = 3'd7;

	localparam logic [ByteW-1:0] F_S  = 8'h80;
	localparam logic [ByteW-1:0] F_Z  = 8'h40;
	localparam logic [ByteW-1:0] F_Y  = 8'h20;
	localparam logic [ByteW-1:0] F_H  = 8'h10;
	localparam logic [ByteW-1:0] F_X  = 8'h08;
	localparam logic [ByteW-1:0] F_P  = 8'h04;
	localparam logic [ByteW-1:0] F_N  = 8'h02;
	localparam logic [ByteW-1:0] F_C  = 8'h01;
	localparam logic [ByteW-1:0] F_XY = 8'h28;
	localparam logic [ByteW-1:0] F_SZP = 8'hC4;

	localparam logic [ByteW-1:0] DAA_LIMIT_HI = 8'h99;
	localparam logic [3:0]       DAA_LIMIT_LO = 4'h9;
	localparam logic [ByteW-1:0] DAA_CORR_HI  = 8'h60;
	localparam logic [ByteW-1:0] DAA_CORR_LO  = 8'h06;
	localparam logic [ByteW-1:0] INC_OVF      = 8'h7F;
	localparam logic [ByteW-1:0] DEC_OVF      = 8'h80;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [ByteW-1:0] operand_a;
		logic [ByteW-1:0] operand_b;
		logic             carry_in;
		logic [ByteW-1:0] old_flags;
		logic [ByteW-1:0] q_latch;
		logic [BitW-1:0]  bit_index;
		logic [ByteW-1:0] xy_source;
	} alu_in_t;

	typedef struct packed {
		logic [ByteW-1:0] result;
		logic [ByteW-1:0] new_flags;
	} alu_out_t;

endpackage

FILE: design/alu_flag_generator_8bit.sv
// Top level: input register, ALU flag logic and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | cmd operand_a operand_b carry_in old_flags
//          |                      | q_latch bit_index xy_source
//  out     | out_valid / out_stall| result new_flags
//
// One transaction per cycle sustained while out_stall is low; out_valid rises when the
// result register loads from the flag logic behind the input register after acceptance.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled result holds in the result register while the input register still
// takes a transaction; in_stall rises only when both registers are full.
module alu_flag_generator_8bit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [afg_pkg::CmdW-1:0]     cmd,
	input  logic [afg_pkg::ByteW-1:0]    operand_a,
	input  logic [afg_pkg::ByteW-1:0]    operand_b,
	input  logic                         carry_in,
	input  logic [afg_pkg::ByteW-1:0]    old_flags,
	input  logic [afg_pkg::ByteW-1:0]    q_latch,
	input  logic [afg_pkg::BitW-1:0]     bit_index,
	input  logic [afg_pkg::ByteW-1:0]    xy_source,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [afg_pkg::ByteW-1:0]    result,
	output logic [afg_pkg::ByteW-1:0]    new_flags
);

	afg_pkg::alu_in_t  op_s1;
	afg_pkg::alu_out_t res_comb;
	afg_pkg::alu_out_t res_s2;
	logic              valid_s1, valid_s2;
	logic              free_s2, adv_s1, take_in;

	assign free_s2  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && free_s2;
	assign in_stall = valid_s1 && !free_s2;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1.cmd       <= cmd;
			op_s1.operand_a <= operand_a;
			op_s1.operand_b <= operand_b;
			op_s1.carry_in  <= carry_in;
			op_s1.old_flags <= old_flags;
			op_s1.q_latch   <= q_latch;
			op_s1.bit_index <= bit_index;
			op_s1.xy_source <= xy_source;
		end
	end

	afg_core u_core (
		.op  (op_s1),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign result    = res_s2.result;
	assign new_flags = res_s2.new_flags;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled without both stages full");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !free_s2) |=> valid_s1)
		else $error("blocked transaction dropped from input stage");

	a_adv_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advanced transaction missing from result stage");

	a_drain_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_stall && !adv_s1) |=> !valid_s2)
		else $error("delivered result repeated");
`endif

endmodule

FILE: design/afg_core.sv
// Result byte and flag byte logic for one ALU operation.
module afg_core (
	input  afg_pkg::alu_in_t  op,
	output afg_pkg::alu_out_t res
);

	function automatic logic [7:0] szxy(input logic [7:0] r);
		szxy = {r[7], (r == 8'h00), r[5], 1'b0, r[3], 3'b000};
	endfunction

	function automatic logic [7:0] par(input logic [7:0] r);
		par = (^r) ? 8'h00 : afg_pkg::F_P;
	endfunction

	logic [7:0] a, b, of;
	logic       ci, oc, nf, hf;
	logic [8:0] sum9, dif9;
	logic [4:0] hsum, hdif;
	logic [4:0] sh_idx;
	logic [2:0] sh_op;
	logic [7:0] sh_r;
	logic       sh_c;
	logic [7:0] daa_corr, daa_r;
	logic       daa_c, daa_h;
	logic       bit_t;

	assign a  = op.operand_a;
	assign b  = op.operand_b;
	assign of = op.old_flags;
	assign ci = op.carry_in;
	assign oc = op.old_flags[0];
	assign nf = op.old_flags[1];
	assign hf = op.old_flags[4];

	assign sum9 = {1'b0, a} + {1'b0, b} + {8'd0, ci};
	assign dif9 = {1'b0, a} - {1'b0, b} - {8'd0, ci};
	assign hsum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
	assign hdif = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

	assign sh_idx = (op.cmd >= afg_pkg::CMD_RLC) ? (op.cmd - afg_pkg::CMD_RLC)
	                                              : (op.cmd - afg_pkg::CMD_RLCA);
	assign sh_op  = sh_idx[2:0];

	always_comb begin
		unique case (sh_op)
			afg_pkg::SH_RLC: begin sh_c = a[7]; sh_r = {a[6:0], a[7]}; end
			afg_pkg::SH_RRC: begin sh_c = a[0]; sh_r = {a[0], a[7:1]}; end
			afg_pkg::SH_RL:  begin sh_c = a[7]; sh_r = {a[6:0], oc};   end
			afg_pkg::SH_RR:  begin sh_c = a[0]; sh_r = {oc, a[7:1]};   end
			afg_pkg::SH_SLA: begin sh_c = a[7]; sh_r = {a[6:0], 1'b0}; end
			afg_pkg::SH_SRA: begin sh_c = a[0]; sh_r = {a[7], a[7:1]}; end
			afg_pkg::SH_SLL: begin sh_c = a[7]; sh_r = {a[6:0], 1'b1}; end
			afg_pkg::SH_SRL: begin sh_c = a[0]; sh_r = {1'b0, a[7:1]}; end
			default:         begin sh_c = a[0]; sh_r = {1'b0, a[7:1]}; end
		endcase
	end

	always_comb begin
		daa_corr = 8'h00;
		daa_c    = oc;
		if (hf || (a[3:0] > afg_pkg::DAA_LIMIT_LO))
			daa_corr = daa_corr | afg_pkg::DAA_CORR_LO;
		if (oc || (a > afg_pkg::DAA_LIMIT_HI)) begin
			daa_corr = daa_corr | afg_pkg::DAA_CORR_HI;
			daa_c    = 1'b1;
		end
		daa_r = nf ? (a - daa_corr) : (a + daa_corr);
		daa_h = nf ? (hf && (a[3:0] < 4'h6)) : (a[3:0] > afg_pkg::DAA_LIMIT_LO);
	end

	assign bit_t = a[op.bit_index];

	always_comb begin
		res.result    = a;
		res.new_flags = of;
		unique case (op.cmd)
			afg_pkg::CMD_ADD: begin
				res.result    = sum9[7:0];
				res.new_flags = szxy(sum9[7:0])
				              | (hsum[4] ? afg_pkg::F_H : 8'h00)
				              | ((~(a[7] ^ b[7]) & (a[7] ^ sum9[7])) ? afg_pkg::F_P : 8'h00)
				              | (sum9[8] ? afg_pkg::F_C : 8'h00);
			end
			afg_pkg::CMD_SUB, afg_pkg::CMD_CP: begin
				res.result    = dif9[7:0];
				res.new_flags = (szxy(dif9[7:0]) & ~afg_pkg::F_XY) | afg_pkg::F_N
				              | (hdif[4] ? afg_pkg::F_H : 8'h00)
				              | (((a[7] ^ b[7]) & (a[7] ^ dif9[7])) ? afg_pkg::F_P : 8'h00)
				              | (dif9[8] ? afg_pkg::F_C : 8'h00)
				              | (((op.cmd == afg_pkg::CMD_CP) ? b : dif9[7:0]) & afg_pkg::F_XY);
			end
			afg_pkg::CMD_AND: begin
				res.result    = a & b;
				res.new_flags = szxy(a & b) | par(a & b) | afg_pkg::F_H;
			end
			afg_pkg::CMD_OR: begin
				res.result    = a | b;
				res.new_flags = szxy(a | b) | par(a | b);
			end
			afg_pkg::CMD_XOR: begin
				res.result    = a ^ b;
				res.new_flags = szxy(a ^ b) | par(a ^ b);
			end
			afg_pkg::CMD_INC: begin
				res.result    = a + 8'd1;
				res.new_flags = {7'd0, oc} | szxy(a + 8'd1)
				              | ((a[3:0] == 4'hF) ? afg_pkg::F_H : 8'h00)
				              | ((a == afg_pkg::INC_OVF) ? afg_pkg::F_P : 8'h00);
			end
			afg_pkg::CMD_DEC: begin
				res.result    = a - 8'd1;
				res.new_flags = {7'd0, oc} | afg_pkg::F_N | szxy(a - 8'd1)
				              | ((a[3:0] == 4'h0) ? afg_pkg::F_H : 8'h00)
				              | ((a == afg_pkg::DEC_OVF) ? afg_pkg::F_P : 8'h00);
			end
			afg_pkg::CMD_RLCA, afg_pkg::CMD_RRCA, afg_pkg::CMD_RLA, afg_pkg::CMD_RRA: begin
				res.result    = sh_r;
				res.new_flags = (of & afg_pkg::F_SZP) | (sh_r & afg_pkg::F_XY) | {7'd0, sh_c};
			end
			afg_pkg::CMD_RLC, afg_pkg::CMD_RRC, afg_pkg::CMD_RL, afg_pkg::CMD_RR,
			afg_pkg::CMD_SLA, afg_pkg::CMD_SRA, afg_pkg::CMD_SLL, afg_pkg::CMD_SRL: begin
				res.result    = sh_r;
				res.new_flags = szxy(sh_r) | par(sh_r) | {7'd0, sh_c};
			end
			afg_pkg::CMD_BIT: begin
				res.new_flags = {7'd0, oc} | afg_pkg::F_H | (op.xy_source & afg_pkg::F_XY)
				              | (bit_t ? 8'h00 : (afg_pkg::F_Z | afg_pkg::F_P))
				              | ((bit_t && (op.bit_index == 3'd7)) ? afg_pkg::F_S : 8'h00);
			end
			afg_pkg::CMD_DAA: begin
				res.result    = daa_r;
				res.new_flags = szxy(daa_r) | par(daa_r) | (nf ? afg_pkg::F_N : 8'h00)
				              | {7'd0, daa_c} | (daa_h ? afg_pkg::F_H : 8'h00);
			end
			afg_pkg::CMD_SCF: begin
				res.new_flags = (of & afg_pkg::F_SZP) | afg_pkg::F_C
				              | ((a | op.q_latch) & afg_pkg::F_XY);
			end
			afg_pkg::CMD_CCF: begin
				res.new_flags = (of & afg_pkg::F_SZP) | (oc ? afg_pkg::F_H : afg_pkg::F_C)
				              | ((a | op.q_latch) & afg_pkg::F_XY);
			end
			afg_pkg::CMD_CPL: begin
				res.result    = ~a;
				res.new_flags = (of & (afg_pkg::F_SZP | afg_pkg::F_C))
				              | afg_pkg::F_H | afg_pkg::F_N | (~a & afg_pkg::F_XY);
			end
			default: begin
				res.result    = a;
				res.new_flags = of;
			end
		endcase
	end

endmodule
